/* rtl/mt19937_random_generator_top_defines.svh */
// Assertion helpers used by the checker file.
`ifndef MT19937_RANDOM_GENERATOR_TOP_DEFINES_SVH
`define MT19937_RANDOM_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, idle while i_rst_n is low.
`define MT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, idle while i_rst_n is low.
`define MT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mt_pkg.sv */
`timescale 1ns / 1ps

package mt_pkg;

    // State bank geometry
    localparam int STATE_WORDS   = 624;
    localparam int SHIFT_DIST    = 397;
    localparam int STATE_AW      = $clog2(STATE_WORDS);
    localparam int POS_W         = $clog2(STATE_WORDS + 2);
    localparam int KEY_WORDS_DEF = 16;

    localparam logic [STATE_AW-1:0] IDX_LAST  = STATE_AW'(STATE_WORDS - 1);
    localparam logic [STATE_AW-1:0] IDX_LAST2 = STATE_AW'(STATE_WORDS - 2);
    localparam logic [STATE_AW-1:0] IDX_SHIFT = STATE_AW'(SHIFT_DIST);
    localparam logic [POS_W-1:0]    POS_FULL  = POS_W'(STATE_WORDS);
    localparam logic [POS_W-1:0]    POS_NEVER = POS_W'(STATE_WORDS + 1);

    // Algorithm constants
    localparam logic [31:0] MAG_XOR      = 32'h9908_b0df;
    localparam logic [31:0] TOP_BIT_MASK = 32'h8000_0000;
    localparam logic [31:0] LOW_31_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] MULT_INIT    = 32'd1812433253;
    localparam logic [31:0] MULT_KEY     = 32'd1664525;
    localparam logic [31:0] MULT_MIX     = 32'd1566083941;
    localparam logic [31:0] ARRAY_SEED   = 32'd19650218;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    // Request codes
    localparam logic [1:0] REQ_DRAW   = 2'd0;
    localparam logic [1:0] REQ_SEED   = 2'd1;
    localparam logic [1:0] REQ_KEY    = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Register map: index bit of the byte address
    localparam int   APB_AW         = 3;
    localparam logic REG_SEED_VALUE = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_KEY_WR,
        ST_SEED_W0,
        ST_SEED_MUL,
        ST_SEED_WR,
        ST_ARR_INIT,
        ST_A1_RD,
        ST_A1_WR,
        ST_A2_RD,
        ST_A2_WR,
        ST_ARR_W0,
        ST_REGEN_PRE,
        ST_REGEN_CAP,
        ST_REGEN_RD,
        ST_REGEN_WR,
        ST_DRAW_RD,
        ST_DRAW_OUT
    } t_state;

    typedef enum logic [1:0] {
        MODE_DRAW,
        MODE_SEED,
        MODE_KEY
    } t_mode;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_KEY_WR,
        DP_SEED_W0,
        DP_SEED_MUL,
        DP_SEED_WR,
        DP_ARR_INIT,
        DP_ARR_RD,
        DP_ARR_WR1,
        DP_ARR_WR2,
        DP_ARR_W0,
        DP_REGEN_PRE,
        DP_REGEN_CAP,
        DP_REGEN_RD,
        DP_REGEN_WR,
        DP_DRAW_RD,
        DP_DRAW_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        SRC_REG,
        SRC_DEFAULT,
        SRC_ARRAY
    } t_seed_src;

    typedef enum logic [1:0] {
        MUL_INIT,
        MUL_KEY,
        MUL_MIX
    } t_mul_sel;

    typedef struct packed {
        logic      capture;
        t_dp_op    op;
        t_seed_src seed_src;
        t_mul_sel  mul_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic pos_used;
        logic never_seeded;
        logic key_last;
        logic idx_last;
        logic kc_last1;
        logic kc_last2;
    } t_dp_stat;

endpackage

/* rtl/mt19937_random_generator_top.sv */
`timescale 1ns / 1ps
// MT19937 word generator, 624-word state bank.
// Requests: raise start with i_req_type (0 draw, 1 seed from seed_value, 2 key word
// with i_key_word and i_key_last); a word is accepted at an edge with start high and
// busy low. A draw answers with o_random_word and a one-cycle o_valid strobe; the
// receiver cannot stall, so take the word in that cycle. Seed and key words give none.
// Steps taken while busy after the accept edge (a draw's strobe follows them):
//   draw from a live block       read and temper the next word
//   draw that twists the block   setup, update of every word, then read and temper
//   first draw never seeded      a seed with 5489 runs first, then twist and draw
//   seed request                 word 0, then multiply and write over 623 words
//   key word, not last           store the word while the key store has room
//   key word marked last         scalar seed, 624 + 623 mixing steps, final word
// The shared 32x32 multiplier or the registered read of the state bank sits in front
// of the update of every state word.
// Reset sets seed_value to 5489 and marks the bank as never seeded; no clearing pass.
// seed_value sits at byte address 0 of the APB port; pready is always high.
module mt19937_random_generator_top
    import mt_pkg::*;
#(
    parameter int KEY_WORDS = KEY_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_req_type,
    input  logic [31:0]       i_key_word,
    input  logic              i_key_last,
    output logic [31:0]       o_random_word,
    output logic              o_valid,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0] r_seed_value;
    logic        w_cfg_we;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;

    // Seed register write and read back
    assign w_cfg_we = psel && penable && pwrite && (paddr[APB_AW-1] == REG_SEED_VALUE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[APB_AW-1] == REG_SEED_VALUE) ? r_seed_value : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_value <= DEFAULT_SEED;
        end else if (w_cfg_we) begin
            r_seed_value <= pwdata;
        end
    end

    mt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_busy     (busy),
        .o_cmd      (w_cmd)
    );

    mt_dp #(.KEY_WORDS(KEY_WORDS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_seed_value  (r_seed_value),
        .i_key_word    (i_key_word),
        .i_key_last    (i_key_last),
        .o_random_word (o_random_word),
        .o_valid       (o_valid)
    );

endmodule

/* rtl/mt_ram.sv */
`timescale 1ns / 1ps

module mt_ram #(
    parameter int   WIDTH = 32,
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word a cycle with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mt_dp.sv */
`timescale 1ns / 1ps

module mt_dp
    import mt_pkg::*;
#(
    parameter int KEY_WORDS = KEY_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_key_word,
    input  logic        i_key_last,
    output logic [31:0] o_random_word,
    output logic        o_valid
);

    localparam int KEY_AW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int CNT_W  = $clog2(KEY_WORDS + 1);
    localparam logic [CNT_W-1:0] KEY_FULL = CNT_W'(KEY_WORDS);

    function automatic logic [31:0] temper(input logic [31:0] v);
        logic [31:0] y;
        y = v ^ (v >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [31:0]         r_key_word, n_key_word;
    logic                r_key_last, n_key_last;
    logic [31:0]         r_prev, n_prev;
    logic [31:0]         r_prod, n_prod;
    logic [31:0]         r_cur, n_cur;
    logic [STATE_AW-1:0] r_idx, n_idx;
    logic [STATE_AW-1:0] r_m, n_m;
    logic [STATE_AW-1:0] r_kc, n_kc;
    logic [KEY_AW-1:0]   r_j, n_j;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_key_cnt, n_key_cnt;
    logic [31:0]         r_word, n_word;
    logic                r_valid, n_valid;

    logic [31:0]         w_mix, w_mul_c, w_product, w_seed, w_y;
    logic [31:0]         w_rd_a, w_rd_b, w_key_rd;
    logic [31:0]         w_wdata;
    logic                w_we, w_key_we;
    logic [STATE_AW-1:0] w_waddr, w_raddr_a, w_idx_inc, w_idx_wrap1, w_m_inc;
    logic [KEY_AW-1:0]   w_j_inc;
    logic [31:0]         w_arr1_val, w_arr2_val, w_regen_val;

    // Shared multiplier on the mixed previous word
    assign w_mix = r_prev ^ (r_prev >> 30);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_KEY: w_mul_c = MULT_KEY;
            MUL_MIX: w_mul_c = MULT_MIX;
            default: w_mul_c = MULT_INIT;
        endcase
    end

    assign w_product = w_mix * w_mul_c;

    // Pick the scalar seed
    always_comb begin
        case (i_cmd.seed_src)
            SRC_DEFAULT: w_seed = DEFAULT_SEED;
            SRC_ARRAY:   w_seed = ARRAY_SEED;
            default:     w_seed = i_seed_value;
        endcase
    end

    // Index steps
    assign w_idx_inc   = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
    assign w_idx_wrap1 = (r_idx == IDX_LAST) ? STATE_AW'(1) : r_idx + 1'b1;
    assign w_m_inc     = (r_m == IDX_LAST) ? '0 : r_m + 1'b1;
    assign w_j_inc     = ((CNT_W'(r_j) + 1'b1) >= r_key_cnt) ? '0 : r_j + 1'b1;

    // Word values of the array seeding and twist
    assign w_arr1_val  = (w_rd_a ^ r_prod) + w_key_rd + 32'(r_j);
    assign w_arr2_val  = (w_rd_a ^ r_prod) - 32'(r_idx);
    assign w_y         = (r_cur & TOP_BIT_MASK) | (w_rd_a & LOW_31_MASK);
    assign w_regen_val = w_rd_b ^ (w_y >> 1) ^ (w_y[0] ? MAG_XOR : 32'd0);

    // Sequence the datapath by command
    always_comb begin
        n_key_word = r_key_word;
        n_key_last = r_key_last;
        n_prev     = r_prev;
        n_prod     = r_prod;
        n_cur      = r_cur;
        n_idx      = r_idx;
        n_m        = r_m;
        n_kc       = r_kc;
        n_j        = r_j;
        n_pos      = r_pos;
        n_key_cnt  = r_key_cnt;
        n_word     = r_word;
        n_valid    = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wdata    = w_seed;
        w_raddr_a  = r_idx;
        w_key_we   = 1'b0;

        if (i_cmd.capture) begin
            n_key_word = i_key_word;
            n_key_last = i_key_last;
        end

        case (i_cmd.op)
            DP_KEY_WR: begin
                if (r_key_cnt < KEY_FULL) begin
                    w_key_we  = 1'b1;
                    n_key_cnt = r_key_cnt + 1'b1;
                end
            end
            DP_SEED_W0: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = w_seed;
                n_prev  = w_seed;
                n_idx   = STATE_AW'(1);
            end
            DP_SEED_MUL: begin
                n_prod = w_product;
            end
            DP_SEED_WR: begin
                w_we    = 1'b1;
                w_wdata = r_prod + 32'(r_idx);
                n_prev  = r_prod + 32'(r_idx);
                n_idx   = w_idx_inc;
                if (r_idx == IDX_LAST) begin
                    n_pos = POS_FULL;
                end
            end
            DP_ARR_INIT: begin
                n_prev = ARRAY_SEED;
                n_idx  = STATE_AW'(1);
                n_kc   = '0;
                n_j    = '0;
            end
            DP_ARR_RD: begin
                n_prod = w_product;
            end
            DP_ARR_WR1: begin
                w_we    = 1'b1;
                w_wdata = w_arr1_val;
                n_prev  = w_arr1_val;
                n_idx   = w_idx_wrap1;
                n_j     = w_j_inc;
                n_kc    = (r_kc == IDX_LAST) ? '0 : r_kc + 1'b1;
            end
            DP_ARR_WR2: begin
                w_we    = 1'b1;
                w_wdata = w_arr2_val;
                n_prev  = w_arr2_val;
                n_idx   = w_idx_wrap1;
                n_kc    = r_kc + 1'b1;
            end
            DP_ARR_W0: begin
                w_we      = 1'b1;
                w_waddr   = '0;
                w_wdata   = TOP_BIT_MASK;
                n_pos     = POS_FULL;
                n_key_cnt = '0;
            end
            DP_REGEN_PRE: begin
                w_raddr_a = '0;
                n_idx     = '0;
                n_m       = IDX_SHIFT;
            end
            DP_REGEN_CAP: begin
                n_cur = w_rd_a;
            end
            DP_REGEN_RD: begin
                w_raddr_a = w_idx_inc;
            end
            DP_REGEN_WR: begin
                w_we    = 1'b1;
                w_wdata = w_regen_val;
                n_cur   = w_rd_a;
                n_idx   = w_idx_inc;
                n_m     = w_m_inc;
                if (r_idx == IDX_LAST) begin
                    n_pos = '0;
                end
            end
            DP_DRAW_RD: begin
                w_raddr_a = r_pos[STATE_AW-1:0];
            end
            DP_DRAW_OUT: begin
                n_word  = temper(w_rd_a);
                n_valid = 1'b1;
                n_pos   = r_pos + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_NEVER;
            r_key_cnt <= '0;
            r_valid   <= 1'b0;
            r_idx     <= '0;
            r_m       <= '0;
            r_kc      <= '0;
            r_j       <= '0;
            r_key_last <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_key_cnt  <= n_key_cnt;
            r_valid    <= n_valid;
            r_idx      <= n_idx;
            r_m        <= n_m;
            r_kc       <= n_kc;
            r_j        <= n_j;
            r_key_last <= n_key_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_word <= n_key_word;
        r_prev     <= n_prev;
        r_prod     <= n_prod;
        r_cur      <= n_cur;
        r_word     <= n_word;
    end

    // Mirror the state bank so the twist reads two words a cycle
    mt_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rd_a)
    );

    mt_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_m),
        .o_rdata (w_rd_b)
    );

    // Key store
    mt_ram #(.WIDTH(32), .DEPTH(KEY_WORDS)) u_key (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_key_cnt[KEY_AW-1:0]),
        .i_wdata (r_key_word),
        .i_raddr (r_j),
        .o_rdata (w_key_rd)
    );

    // Report progress to the controller
    assign o_stat.pos_used     = (r_pos >= POS_FULL);
    assign o_stat.never_seeded = (r_pos == POS_NEVER);
    assign o_stat.key_last     = r_key_last;
    assign o_stat.idx_last     = (r_idx == IDX_LAST);
    assign o_stat.kc_last1     = (r_kc == IDX_LAST);
    assign o_stat.kc_last2     = (r_kc == IDX_LAST2);

    assign o_random_word = r_word;
    assign o_valid       = r_valid;

endmodule

/* rtl/mt_ctrl.sv */
`timescale 1ns / 1ps

module mt_ctrl
    import mt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_req_type,
    input  t_dp_stat   i_stat,
    output logic       o_busy,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    // Next state
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_req_type)
                        REQ_DRAW: begin
                            n_mode = MODE_DRAW;
                            if (i_stat.never_seeded) begin
                                n_state = ST_SEED_W0;
                            end else if (i_stat.pos_used) begin
                                n_state = ST_REGEN_PRE;
                            end else begin
                                n_state = ST_DRAW_RD;
                            end
                        end
                        REQ_SEED: begin
                            n_mode  = MODE_SEED;
                            n_state = ST_SEED_W0;
                        end
                        REQ_KEY: begin
                            n_mode  = MODE_KEY;
                            n_state = ST_KEY_WR;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_KEY_WR:   n_state = i_stat.key_last ? ST_SEED_W0 : ST_IDLE;
            ST_SEED_W0:  n_state = ST_SEED_MUL;
            ST_SEED_MUL: n_state = ST_SEED_WR;
            ST_SEED_WR: begin
                if (!i_stat.idx_last) begin
                    n_state = ST_SEED_MUL;
                end else begin
                    case (r_mode)
                        MODE_DRAW: n_state = ST_REGEN_PRE;
                        MODE_KEY:  n_state = ST_ARR_INIT;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ARR_INIT:  n_state = ST_A1_RD;
            ST_A1_RD:     n_state = ST_A1_WR;
            ST_A1_WR:     n_state = i_stat.kc_last1 ? ST_A2_RD : ST_A1_RD;
            ST_A2_RD:     n_state = ST_A2_WR;
            ST_A2_WR:     n_state = i_stat.kc_last2 ? ST_ARR_W0 : ST_A2_RD;
            ST_ARR_W0:    n_state = ST_IDLE;
            ST_REGEN_PRE: n_state = ST_REGEN_CAP;
            ST_REGEN_CAP: n_state = ST_REGEN_RD;
            ST_REGEN_RD:  n_state = ST_REGEN_WR;
            ST_REGEN_WR:  n_state = i_stat.idx_last ? ST_DRAW_RD : ST_REGEN_RD;
            ST_DRAW_RD:   n_state = ST_DRAW_OUT;
            ST_DRAW_OUT:  n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd.capture  = (r_state == ST_IDLE) && i_start;
        o_cmd.mul_sel  = MUL_INIT;
        case (r_mode)
            MODE_DRAW: o_cmd.seed_src = SRC_DEFAULT;
            MODE_KEY:  o_cmd.seed_src = SRC_ARRAY;
            default:   o_cmd.seed_src = SRC_REG;
        endcase
        case (r_state)
            ST_KEY_WR:    o_cmd.op = DP_KEY_WR;
            ST_SEED_W0:   o_cmd.op = DP_SEED_W0;
            ST_SEED_MUL:  o_cmd.op = DP_SEED_MUL;
            ST_SEED_WR:   o_cmd.op = DP_SEED_WR;
            ST_ARR_INIT:  o_cmd.op = DP_ARR_INIT;
            ST_A1_RD: begin
                o_cmd.op      = DP_ARR_RD;
                o_cmd.mul_sel = MUL_KEY;
            end
            ST_A1_WR:     o_cmd.op = DP_ARR_WR1;
            ST_A2_RD: begin
                o_cmd.op      = DP_ARR_RD;
                o_cmd.mul_sel = MUL_MIX;
            end
            ST_A2_WR:     o_cmd.op = DP_ARR_WR2;
            ST_ARR_W0:    o_cmd.op = DP_ARR_W0;
            ST_REGEN_PRE: o_cmd.op = DP_REGEN_PRE;
            ST_REGEN_CAP: o_cmd.op = DP_REGEN_CAP;
            ST_REGEN_RD:  o_cmd.op = DP_REGEN_RD;
            ST_REGEN_WR:  o_cmd.op = DP_REGEN_WR;
            ST_DRAW_RD:   o_cmd.op = DP_DRAW_RD;
            ST_DRAW_OUT:  o_cmd.op = DP_DRAW_OUT;
            default:      o_cmd.op = DP_NOP;
        endcase
        o_busy = (r_state != ST_IDLE);
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_DRAW;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule

/* rtl/mt_checker.sv */
`timescale 1ns / 1ps
`include "mt19937_random_generator_top_defines.svh"

module mt_checker
    import mt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_req_type,
    input logic       o_valid
);

    // A word is only shown once the sequencer is back at rest
    `MT_ASSERT_NOW(a_word_when_idle, o_valid, !busy, "word shown while busy")

    // The strobe lasts one cycle
    `MT_ASSERT_NEXT(a_strobe_pulse, o_valid, !o_valid, "strobe longer than one cycle")

    // A valid request keeps the block busy and shows no word straight after
    `MT_ASSERT_NEXT(a_accept_busy, start && !busy && (i_req_type != REQ_UNUSED), busy && !o_valid, "request accepted but block not busy")

    // The block only turns busy on an accepted request
    `MT_ASSERT_NOW(a_busy_from_start, $rose(busy), $past(start), "busy rose without a request")

endmodule

bind mt19937_random_generator_top mt_checker u_mt_checker (.*);
